// File: hdl/tcw_pkg.sv
// Shared types, widths, constants and the hex glyph function of the text console writer.
package tcw_pkg;

    localparam int ACTION_W     = 3;
    localparam int CHAR_W       = 8;
    localparam int HEX_W        = 64;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int BG_W         = 4;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int DIGIT_CNT_W  = 5;

    localparam logic [CHAR_W-1:0]      SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]      GLYPH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]      GLYPH_A      = 8'h41;
    localparam logic [DIGIT_CNT_W-1:0] CHAR_DIGITS  = 5'd1;
    localparam logic [DIGIT_CNT_W-1:0] BYTE_DIGITS  = 5'd2;
    localparam logic [DIGIT_CNT_W-1:0] WORD_DIGITS  = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 3'd0,
        ACT_LF    = 3'd1,
        ACT_HEX8  = 3'd2,
        ACT_HEX64 = 3'd3,
        ACT_CLEAR = 3'd4,
        ACT_READ  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    // Upper-case hex digit for one nibble
    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nibble);
        logic [CHAR_W-1:0] wide;
        wide = {4'b0000, nibble};
        if (nibble < 4'd10) begin
            return GLYPH_ZERO + wide;
        end
        return GLYPH_A + wide - 8'd10;
    endfunction

endpackage

// File: hdl/tcw_if.sv
// Valid/ready channel interfaces for the console command and result items.
interface tcw_in_if;
    import tcw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [CHAR_W-1:0]     char_code;
    logic [HEX_W-1:0]      hex_value;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_column;

    modport source (
        output valid, action, char_code, hex_value, read_row, read_column,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, hex_value, read_row, read_column,
        output ready
    );
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHAR_W-1:0]       cell_char;
    logic [BG_W-1:0]         cell_background;
    logic [CURSOR_COL_W-1:0] cursor_column;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic                    did_scroll;

    modport source (
        output valid, cell_char, cell_background, cursor_column, cursor_row, did_scroll,
        input  ready
    );
    modport sink (
        input  valid, cell_char, cell_background, cursor_column, cursor_row, did_scroll,
        output ready
    );
endinterface

// File: hdl/text_console_writer_unit.sv
// Top level of the text console writer: sequencer and screen store.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------------
//  i_in     | in  | valid/ready        | action, char_code, hex_value, read_row, read_column
//  o_out    | out | valid/ready        | cell_char, cell_background, cursor_column,
//           |     |                    | cursor_row, did_scroll
//
//  Each item is accepted, then its characters are written in turn (put char 1, hex byte 2,
//  hex 64-bit 16); a line feed moves the cursor, a read cell reads the screen if in range,
//  a clear blanks every cell, and each scroll advances the top-row pointer and blanks a row.
//  After reset a blanking pass of ROWS*COLUMNS cells (2000 by default) runs with ready low.
//  A finished result sits in the output register; the next item is accepted meanwhile and
//  its result waits inside the block until the register is taken.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [AW-1:0]     ram_addr;
    logic              ram_wr_en;
    logic [CHAR_W-1:0] ram_wr_data;
    logic [CHAR_W-1:0] ram_rd_data;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_ram_addr    (ram_addr),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_data (ram_wr_data),
        .i_ram_rd_data (ram_rd_data)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_addr    (ram_addr),
        .i_wr_en   (ram_wr_en),
        .i_wr_data (ram_wr_data),
        .o_rd_data (ram_rd_data)
    );

endmodule

// File: hdl/tcw_screen_ram.sv
// Screen character store: one address port, synchronous write, registered read.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       i_clk,
    input  logic [AW-1:0]              i_addr,
    input  logic                       i_wr_en,
    input  logic [tcw_pkg::CHAR_W-1:0] i_wr_data,
    output logic [tcw_pkg::CHAR_W-1:0] o_rd_data
);
    import tcw_pkg::*;

    // Background is always zero on every write, so only the character is kept
    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/tcw_ctrl.sv
// Console sequencer: cursor, row rotation, clear sweeps, screen access and result register.
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcw_in_if.sink                     i_in,
    tcw_out_if.source                  o_out,
    output logic [AW-1:0]              o_ram_addr,
    output logic                       o_ram_wr_en,
    output logic [tcw_pkg::CHAR_W-1:0] o_ram_wr_data,
    input  logic [tcw_pkg::CHAR_W-1:0] i_ram_rd_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    t_state                  r_state, n_state;
    logic [ACTION_W-1:0]     r_action, n_action;
    logic [CHAR_W-1:0]       r_char, n_char;
    logic [HEX_W-1:0]        r_value, n_value;
    logic [DIGIT_CNT_W-1:0]  r_left, n_left;
    logic [CW-1:0]           r_col, n_col;
    logic [RW-1:0]           r_row, n_row;
    logic [RW-1:0]           r_top, n_top;
    logic [RW-1:0]           r_rd_row, n_rd_row;
    logic [CW-1:0]           r_rd_col, n_rd_col;
    logic                    r_rd_ok, n_rd_ok;
    logic                    r_scrolled, n_scrolled;
    logic [CHAR_W-1:0]       r_cell, n_cell;
    logic [AW-1:0]           r_sweep, n_sweep;
    logic [AW-1:0]           r_sweep_end, n_sweep_end;
    logic                    r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]       r_o_char, n_o_char;
    logic [CURSOR_COL_W-1:0] r_o_col, n_o_col;
    logic [CURSOR_ROW_W-1:0] r_o_row, n_o_row;
    logic                    r_o_scroll, n_o_scroll;

    logic          is_read;
    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] scroll_base;
    logic          col_last;
    logic          row_last;
    logic          top_last;

    // Logical row maps to a physical row through the rotating top-row pointer
    assign is_read   = (r_action == ACT_READ);
    assign row_sel   = is_read ? r_rd_row : r_row;
    assign col_sel   = is_read ? r_rd_col : r_col;
    assign row_sum   = {1'b0, row_sel} + {1'b0, r_top};
    assign phys_row  = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
    assign cell_addr = AW'(AW'(phys_row) * AW'(COLUMNS)) + AW'(col_sel);
    assign scroll_base = AW'(AW'(r_top) * AW'(COLUMNS));
    assign col_last  = (r_col == CW'(COLUMNS - 1));
    assign row_last  = (r_row == RW'(ROWS - 1));
    assign top_last  = (r_top == RW'(ROWS - 1));

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.cell_char       = r_o_char;
    assign o_out.cell_background = '0;
    assign o_out.cursor_column   = r_o_col;
    assign o_out.cursor_row      = r_o_row;
    assign o_out.did_scroll      = r_o_scroll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_sweep     <= '0;
            r_sweep_end <= AW'(CELLS - 1);
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_top       <= n_top;
            r_sweep     <= n_sweep;
            r_sweep_end <= n_sweep_end;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_char     <= n_char;
        r_value    <= n_value;
        r_rd_row   <= n_rd_row;
        r_rd_col   <= n_rd_col;
        r_rd_ok    <= n_rd_ok;
        r_scrolled <= n_scrolled;
        r_cell     <= n_cell;
        r_o_char   <= n_o_char;
        r_o_col    <= n_o_col;
        r_o_row    <= n_o_row;
        r_o_scroll <= n_o_scroll;
    end

    always_comb begin
        logic fin;
        logic scroll_go;

        n_state     = r_state;
        n_action    = r_action;
        n_char      = r_char;
        n_value     = r_value;
        n_left      = r_left;
        n_col       = r_col;
        n_row       = r_row;
        n_top       = r_top;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;
        n_rd_ok     = r_rd_ok;
        n_scrolled  = r_scrolled;
        n_cell      = r_cell;
        n_sweep     = r_sweep;
        n_sweep_end = r_sweep_end;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_char    = r_o_char;
        n_o_col     = r_o_col;
        n_o_row     = r_o_row;
        n_o_scroll  = r_o_scroll;

        o_ram_addr    = cell_addr;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_data = SPACE_CHAR;
        fin           = 1'b0;
        scroll_go     = 1'b0;

        case (r_state)
            S_INIT: begin
                o_ram_wr_en = 1'b1;
                o_ram_addr  = r_sweep;
                if (r_sweep == r_sweep_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action   = i_in.action;
                    n_char     = i_in.char_code;
                    n_value    = i_in.hex_value;
                    n_rd_row   = RW'(i_in.read_row);
                    n_rd_col   = CW'(i_in.read_column);
                    n_rd_ok    = (32'(i_in.read_row) < ROWS) && (32'(i_in.read_column) < COLUMNS);
                    n_scrolled = 1'b0;
                    n_cell     = '0;
                    n_state    = S_EXEC;
                    case (t_action'(i_in.action))
                        ACT_PUT:   n_left = CHAR_DIGITS;
                        ACT_HEX8: begin
                            n_left  = BYTE_DIGITS;
                            n_value = {i_in.hex_value[7:0], 56'd0};
                        end
                        ACT_HEX64: n_left = WORD_DIGITS;
                        default:   n_left = '0;
                    endcase
                end
            end
            S_EXEC: begin
                case (t_action'(r_action))
                    ACT_PUT, ACT_HEX8, ACT_HEX64: begin
                        o_ram_wr_en   = 1'b1;
                        o_ram_wr_data = (r_action == ACT_PUT) ? r_char : hex_glyph(r_value[63:60]);
                        n_value       = {r_value[HEX_W-5:0], 4'h0};
                        n_left        = r_left - 1'b1;
                        if (col_last) begin
                            n_col = '0;
                            if (row_last) begin
                                scroll_go = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        if (!scroll_go && r_left == 5'd1) begin
                            fin = 1'b1;
                        end
                    end
                    ACT_LF: begin
                        n_col = '0;
                        if (row_last) begin
                            scroll_go = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                            fin   = 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        n_sweep     = '0;
                        n_sweep_end = AW'(CELLS - 1);
                        n_state     = S_CLEAR;
                    end
                    ACT_READ: begin
                        if (r_rd_ok) begin
                            n_state = S_READ;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end
            S_READ: begin
                n_cell = i_ram_rd_data;
                fin    = 1'b1;
            end
            S_SCROLL, S_CLEAR: begin
                o_ram_wr_en = 1'b1;
                o_ram_addr  = r_sweep;
                if (r_sweep == r_sweep_end) begin
                    if (r_state == S_CLEAR || r_left == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_EXEC;
                    end
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_DONE: fin = 1'b1;
            default: n_state = S_IDLE;
        endcase

        // Scroll: advance the top pointer and blank the old top row, now the bottom
        if (scroll_go) begin
            n_scrolled  = 1'b1;
            n_sweep     = scroll_base;
            n_sweep_end = scroll_base + AW'(COLUMNS - 1);
            n_top       = top_last ? '0 : r_top + 1'b1;
            n_state     = S_SCROLL;
        end

        // Hand the result to the output register, or hold until it frees up
        if (fin) begin
            if (!r_out_valid || o_out.ready) begin
                n_out_valid = 1'b1;
                n_o_char    = n_cell;
                n_o_col     = CURSOR_COL_W'(n_col);
                n_o_row     = CURSOR_ROW_W'(n_row);
                n_o_scroll  = n_scrolled;
                n_state     = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

endmodule

// File: hdl/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_cell_char,
    input logic [3:0] i_out_cell_background,
    input logic [6:0] i_out_cursor_column,
    input logic [4:0] i_out_cursor_row,
    input logic       i_out_did_scroll
);

    // Ready is low in the cycle after an accept, so no two items are taken back to back
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on the cycle after an accept");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_cursor_column) < COLUMNS) && (32'(i_out_cursor_row) < ROWS))
        else $error("cursor outside the screen");

    // A scroll always leaves the cursor on the bottom row
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_did_scroll) |-> (i_out_cursor_row == 5'(ROWS - 1)))
        else $error("scroll reported with cursor off the bottom row");

    a_background_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_cell_background == 4'd0))
        else $error("non-zero background in result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_cell_char)
            && $stable(i_out_cursor_column) && $stable(i_out_cursor_row)
            && $stable(i_out_did_scroll))
        else $error("stalled result changed");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_cell_char       (o_out.cell_char),
    .i_out_cell_background (o_out.cell_background),
    .i_out_cursor_column   (o_out.cursor_column),
    .i_out_cursor_row      (o_out.cursor_row),
    .i_out_did_scroll      (o_out.did_scroll)
);

// File: bench/tcw_console_checker.sv
// Console checker: watches both channels, predicts each result item and compares it.
`timescale 1ns / 100ps

module tcw_console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  logic                             i_cmd_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]     i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::HEX_W-1:0]        i_hex_value,
    input  logic [tcw_pkg::READ_ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::READ_COL_W-1:0]   i_read_column,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_cell_char,
    input  logic [tcw_pkg::BG_W-1:0]         i_cell_background,
    input  logic [tcw_pkg::CURSOR_COL_W-1:0] i_cursor_column,
    input  logic [tcw_pkg::CURSOR_ROW_W-1:0] i_cursor_row,
    input  logic                             i_did_scroll,
    output int                               o_fail_count,
    output int                               o_pending
);
    import tcw_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]       cell_char;
        logic [BG_W-1:0]         cell_background;
        logic [CURSOR_COL_W-1:0] cursor_column;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic                    did_scroll;
    } t_console_report;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MAX_SHOWN  = 10;
    localparam logic [16*CHAR_W-1:0] HEX_GLYPHS = "0123456789ABCDEF";
    localparam logic [BG_W-1:0]      BG_BLANK   = '0;

    logic [BG_W+CHAR_W-1:0] screen_model [0:CELL_COUNT-1];
    int                     col_pos;
    int                     row_pos;
    t_console_report        console_reports[$];
    int                     mismatches = 0;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] nibble);
        return HEX_GLYPHS[(15 - nibble) * CHAR_W +: CHAR_W];
    endfunction

    task blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = {BG_BLANK, SPACE_CHAR};
        end
    endtask

    task scroll_up();
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
        end
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_model[i] = {BG_BLANK, SPACE_CHAR};
        end
    endtask

    task advance_row(output bit scrolled);
        col_pos  = 0;
        row_pos  = row_pos + 1;
        scrolled = 1'b0;
        if (row_pos >= ROWS) begin
            row_pos  = ROWS - 1;
            scroll_up();
            scrolled = 1'b1;
        end
    endtask

    task write_glyph(input logic [CHAR_W-1:0] glyph, inout bit scrolled);
        bit wrapped;
        wrapped = 1'b0;
        screen_model[row_pos * COLUMNS + col_pos] = {BG_BLANK, glyph};
        col_pos = col_pos + 1;
        if (col_pos >= COLUMNS) begin
            advance_row(wrapped);
        end
        if (wrapped) begin
            scrolled = 1'b1;
        end
    endtask

    task predict_console_step(
        input  logic [ACTION_W-1:0]   act,
        input  logic [CHAR_W-1:0]     ch,
        input  logic [HEX_W-1:0]      hex,
        input  logic [READ_ROW_W-1:0] rrow,
        input  logic [READ_COL_W-1:0] rcol,
        output t_console_report       rep
    );
        bit                     scrolled;
        logic [BG_W+CHAR_W-1:0] stored;
        scrolled = 1'b0;
        rep      = '0;
        case (act)
            ACT_PUT: begin
                write_glyph(ch, scrolled);
            end
            ACT_LF: begin
                advance_row(scrolled);
            end
            ACT_HEX8: begin
                write_glyph(digit_glyph(hex[7:4]), scrolled);
                write_glyph(digit_glyph(hex[3:0]), scrolled);
            end
            ACT_HEX64: begin
                // most significant digit first
                for (int k = 0; k < 16; k++) begin
                    write_glyph(digit_glyph(hex[HEX_W-1-4*k -: 4]), scrolled);
                end
            end
            ACT_CLEAR: begin
                blank_screen();
            end
            ACT_READ: begin
                // out-of-range reads return zero cell fields
                if (rrow < ROWS && rcol < COLUMNS) begin
                    stored              = screen_model[rrow * COLUMNS + rcol];
                    rep.cell_char       = stored[CHAR_W-1:0];
                    rep.cell_background = stored[BG_W+CHAR_W-1:CHAR_W];
                end
            end
            default: begin
            end
        endcase
        rep.cursor_column = col_pos[CURSOR_COL_W-1:0];
        rep.cursor_row    = row_pos[CURSOR_ROW_W-1:0];
        rep.did_scroll    = scrolled;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_console_report predicted;
        t_console_report seen;
        t_console_report due;
        if (!i_rst_n) begin
            blank_screen();
            col_pos = 0;
            row_pos = 0;
            console_reports.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                predict_console_step(i_action, i_char_code, i_hex_value,
                                     i_read_row, i_read_column, predicted);
                console_reports.push_back(predicted);
            end
            if (i_res_valid && i_res_ready) begin
                seen.cell_char       = i_cell_char;
                seen.cell_background = i_cell_background;
                seen.cursor_column   = i_cursor_column;
                seen.cursor_row      = i_cursor_row;
                seen.did_scroll      = i_did_scroll;
                if (console_reports.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: extra result: ch %02h bg %h col %0d row %0d scr %0b",
                                 $realtime, seen.cell_char, seen.cell_background,
                                 seen.cursor_column, seen.cursor_row, seen.did_scroll);
                    end
                end else begin
                    due = console_reports.pop_front();
                    if (seen.cell_char !== due.cell_char
                            || seen.cell_background !== due.cell_background
                            || seen.cursor_column !== due.cursor_column
                            || seen.cursor_row !== due.cursor_row
                            || seen.did_scroll !== due.did_scroll) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("%0t: expected ch %02h bg %h col %0d row %0d scr %0b",
                                     $realtime, due.cell_char, due.cell_background,
                                     due.cursor_column, due.cursor_row, due.did_scroll);
                            $display("%0t: actual   ch %02h bg %h col %0d row %0d scr %0b",
                                     $realtime, seen.cell_char, seen.cell_background,
                                     seen.cursor_column, seen.cursor_row, seen.did_scroll);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= console_reports.size();
    end

endmodule

// File: bench/tb_text_console_writer_unit.sv
// Testbench top: clock, reset, command stimulus, result pacing and the final verdict.
`timescale 1ns / 100ps

module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 2_000_000;

    // action codes the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   long_hold    = 1'b0;
    bit   random_phase = 1'b0;
    int   items_sent   = 0;
    int   cycle_count  = 0;
    int   fail_count;
    int   pending;

    tcw_in_if  cmd_if ();
    tcw_out_if res_if ();

    text_console_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    tcw_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_console_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_if.valid),
        .i_cmd_ready       (cmd_if.ready),
        .i_action          (cmd_if.action),
        .i_char_code       (cmd_if.char_code),
        .i_hex_value       (cmd_if.hex_value),
        .i_read_row        (cmd_if.read_row),
        .i_read_column     (cmd_if.read_column),
        .i_res_valid       (res_if.valid),
        .i_res_ready       (res_if.ready),
        .i_cell_char       (res_if.cell_char),
        .i_cell_background (res_if.cell_background),
        .i_cursor_column   (res_if.cursor_column),
        .i_cursor_row      (res_if.cursor_row),
        .i_did_scroll      (res_if.did_scroll),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap(input int idx);
        // no idling during a hold-off or inside a burst stretch
        if (long_hold || ((idx / 50) % 4 == 1)) begin
            return 0;
        end
        if ($urandom_range(99) < 55) begin
            return 0;
        end
        return idle_length();
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task send_cmd(
        input logic [ACTION_W-1:0]   act,
        input logic [CHAR_W-1:0]     ch,
        input logic [HEX_W-1:0]      hex,
        input logic [READ_ROW_W-1:0] rrow,
        input logic [READ_COL_W-1:0] rcol,
        input int                    gap
    );
        cmd_if.valid       = 1'b1;
        cmd_if.action      = act;
        cmd_if.char_code   = ch;
        cmd_if.hex_value   = hex;
        cmd_if.read_row    = rrow;
        cmd_if.read_column = rcol;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        items_sent = items_sent + 1;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task send_random_cmd(input int idx);
        int                    r;
        logic [ACTION_W-1:0]   act;
        logic [READ_ROW_W-1:0] rrow;
        logic [READ_COL_W-1:0] rcol;
        r = $urandom_range(99);
        if (r < 33) begin
            act = ACT_PUT;
        end else if (r < 47) begin
            act = ACT_LF;
        end else if (r < 59) begin
            act = ACT_HEX8;
        end else if (r < 71) begin
            act = ACT_HEX64;
        end else if (r < 92) begin
            act = ACT_READ;
        end else if (r < 95) begin
            act = ACT_CLEAR;
        end else if (r < 97) begin
            act = ACT_SPARE_6;
        end else begin
            act = ACT_SPARE_7;
        end
        // reads mostly land on the screen, some fall outside it
        if ($urandom_range(99) < 85) begin
            rrow = READ_ROW_W'($urandom_range(ROWS - 1));
            rcol = READ_COL_W'($urandom_range(COLUMNS - 1));
        end else begin
            rrow = READ_ROW_W'($urandom_range(31));
            rcol = READ_COL_W'($urandom_range(127));
        end
        send_cmd(act, CHAR_W'($urandom_range(255)), {$urandom, $urandom},
                 rrow, rcol, sender_gap(idx));
    endtask

    initial begin
        cmd_if.valid       = 1'b0;
        cmd_if.action      = ACT_PUT;
        cmd_if.char_code   = '0;
        cmd_if.hex_value   = '0;
        cmd_if.read_row    = '0;
        cmd_if.read_column = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_PUT,     8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_PUT,     8'hFF, '1,                     5'd31, 7'd127, sender_gap(0));
        send_cmd(ACT_PUT,     8'h20, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_HEX8,    8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_HEX8,    8'h00, '1,                     5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_HEX64,   8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_HEX64,   8'h00, '1,                     5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_HEX64,   8'h00, 64'h0123_4567_89AB_CDEF, 5'd0, 7'd0,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd1,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd25,  sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd24, 7'd79,  sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd25, 7'd0,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd80,  sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd31, 7'd127, sender_gap(0));
        send_cmd(ACT_LF,      8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_SPARE_6, 8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_SPARE_7, 8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_CLEAR,   8'h00, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd0,  7'd3,   sender_gap(0));
        send_cmd(ACT_PUT,     8'h41, 64'h0,                  5'd0,  7'd0,   sender_gap(0));
        send_cmd(ACT_READ,    8'h00, 64'h0,                  5'd1,  7'd0,   sender_gap(0));

        random_phase = 1'b1;
        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            send_random_cmd(idx);
        end
        cmd_if.valid = 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("text_console_writer_unit regression: pass");
        end else begin
            $display("text_console_writer_unit regression: fail");
        end
        $finish;
    end

    // Long receiver hold-offs while the sender keeps offering items.
    initial begin
        while (!random_phase) begin
            @(posedge i_clk);
        end
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
        while (items_sent < 400) begin
            @(posedge i_clk);
        end
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : result_pacing
        int stall_left;
        int calm_left;
        int r;
        res_if.ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                res_if.ready = 1'b0;
            end else if (calm_left > 0) begin
                res_if.ready = 1'b1;
                calm_left    = calm_left - 1;
            end else if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left   = stall_left - 1;
            end else begin
                r = $urandom_range(99);
                if (r < 2) begin
                    calm_left    = $urandom_range(100, 300);
                    res_if.ready = 1'b1;
                end else if (r < 18) begin
                    stall_left   = idle_length() - 1;
                    res_if.ready = 1'b0;
                end else begin
                    res_if.ready = 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
        end
        $display("text_console_writer_unit regression: fail");
        $finish;
    end

endmodule

// File: text_console_writer_unit.f
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_screen_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_unit.sv
hdl/tcw_checker.sv
bench/tcw_console_checker.sv
bench/tb_text_console_writer_unit.sv
